@@ design/mvso_pkg.sv @@
// Package for the multi-voice sine oscillator core.
// Holds widths, rate limits, the note frequency table and the quarter-wave sine helper.
// No dependencies.
package mvso_pkg;

	localparam int VOICES_DEF         = 8;
	localparam int SINE_ADDR_BITS_DEF = 10;

	localparam int SR_W    = 18;
	localparam int FREQ_W  = 34;
	localparam int FRAC_SH = 12;
	localparam int DVD_W   = FREQ_W + FRAC_SH + 1;
	localparam int PHASE_W = 32;
	localparam int SMP_W   = 16;
	localparam int MAG_W   = 15;
	localparam int NOTES   = 128;

	localparam logic [SR_W-1:0] SR_RESET = 18'd48000;
	localparam logic [SR_W-1:0] SR_MIN   = 18'd8000;
	localparam logic [SR_W-1:0] SR_MAX   = 18'd192000;

	localparam logic [63:0] NOTE0_Q20    = 64'd8572947;
	localparam logic [63:0] SEMITONE_Q30 = 64'd1137589835;

	localparam longint C1  = 64'sd1686629713;
	localparam longint C3  = -64'sd693598668;
	localparam longint C5  = 64'sd85569306;
	localparam longint C7  = -64'sd5026995;
	localparam longint C9  = 64'sd172272;
	localparam longint Q30 = 64'sd1073741824;

	typedef logic [FREQ_W-1:0] note_tbl_t [NOTES];

	function automatic note_tbl_t build_note_tbl();
		note_tbl_t   tbl;
		logic [95:0] f;
		f = 96'(NOTE0_Q20);
		for (int i = 0; i < NOTES; i++) begin
			tbl[i] = FREQ_W'(f);
			f = (f * 96'(SEMITONE_Q30) + (96'd1 << 29)) >> 30;
		end
		return tbl;
	endfunction

	localparam note_tbl_t NOTE_TBL = build_note_tbl();

	// Degree-9 odd polynomial for sin(t*pi/2), t in Q30, rounded to Q15 magnitude
	function automatic logic [MAG_W-1:0] sine_mag(longint t);
		longint u;
		longint p;
		longint s;
		u = (t * t) / Q30;
		p = C9;
		p = C7 + (p * u) / Q30;
		p = C5 + (p * u) / Q30;
		p = C3 + (p * u) / Q30;
		p = C1 + (p * u) / Q30;
		s = (p * t) / Q30;
		if (s < 0)
			s = 0;
		s = (s + 64'sd16384) / 64'sd32768;
		if (s > 64'sd32767)
			s = 64'sd32767;
		return MAG_W'(s);
	endfunction

endpackage

@@ design/multi_voice_sine_oscillator_core.sv @@
// Top level of the multi-voice sine oscillator: per-voice phase state in two
// synchronous memories, a bit-serial step divider and a quarter-wave sine table.
// Depends on mvso_pkg.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------------
//   in      | in_valid / in_ready  | action, voice_index, note_number, velocity,
//           |                      | voice_active
//   out     | out_valid / out_ready| out_voice, sample, last
//   cfg     | cfg_we               | cfg_wdata (sample rate)
//
// A tick issues one voice read per cycle while the output is not stalled; the next
// item is taken only after the memory read and table read stages have drained.
// A note event that loads a pitch passes ST_NOTE, the one-bit-per-cycle divider
// (47 steps) and ST_WR before the next item is taken; any other note event leaves the core idle.
// Reset clears voice flags and valid bits at once; no memory clearing pass is run.
// A stalled output holds the whole tick pipeline, including the memory reads.
module multi_voice_sine_oscillator_core #(
	parameter int VOICES         = mvso_pkg::VOICES_DEF,
	parameter int SINE_ADDR_BITS = mvso_pkg::SINE_ADDR_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [mvso_pkg::SR_W-1:0]             cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  action,
	input  logic [2:0]                            voice_index,
	input  logic [6:0]                            note_number,
	input  logic [6:0]                            velocity,
	input  logic                                  voice_active,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [2:0]                            out_voice,
	output logic signed [mvso_pkg::SMP_W-1:0]     sample,
	output logic                                  last
);
	import mvso_pkg::*;

	localparam int VW        = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int QB        = SINE_ADDR_BITS - 2;
	localparam int QN        = 1 << QB;
	localparam int DIV_STEPS = DVD_W;
	localparam int CW        = $clog2(DIV_STEPS);

	typedef logic [MAG_W-1:0] sine_tbl_t [QN+1];

	function automatic sine_tbl_t build_sine_tbl();
		sine_tbl_t tbl;
		for (int x = 0; x <= QN; x++)
			tbl[x] = sine_mag(longint'(x) << (30 - QB));
		return tbl;
	endfunction

	localparam sine_tbl_t SINE_TBL = build_sine_tbl();

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NOTE,
		ST_DIV,
		ST_WR,
		ST_TICK
	} state_t;

	state_t               state_q;
	logic [SR_W-1:0]      sr_q;
	logic [SR_W-1:0]      srl_q;
	logic [VOICES-1:0]    act_q;
	logic [VOICES-1:0]    acc_vld_q;
	logic [VOICES-1:0]    step_vld_q;
	logic [VW-1:0]        v_q;
	logic [VW-1:0]        nv_q;
	logic [6:0]           note_q;
	logic [CW-1:0]        cnt_q;
	logic [DVD_W-1:0]     dvd_q;
	logic [SR_W-1:0]      rem_q;
	logic [PHASE_W-1:0]   quo_q;

	logic [PHASE_W-1:0]   acc_mem  [VOICES];
	logic [PHASE_W-1:0]   step_mem [VOICES];
	logic [PHASE_W-1:0]   acc_rd;
	logic [PHASE_W-1:0]   step_rd;

	logic                 vld_s1, vld_s2;
	logic [VW-1:0]        voice_s1, voice_s2;
	logic                 last_s1, last_s2;
	logic                 act_s1, act_s2;
	logic                 accv_s1, stepv_s1;
	logic                 neg_s2;
	logic [MAG_W-1:0]     mag_s2;

	logic                 out_valid_q;
	logic [2:0]           out_voice_q;
	logic [SMP_W-1:0]     sample_q;
	logic                 last_q;

	logic                 in_acc;
	logic                 adv;
	logic                 rd_en;
	logic [SR_W-1:0]      sr_clamp;
	logic [SR_W:0]        div_r;
	logic                 div_ge;
	logic [SR_W:0]        div_rem;
	logic [PHASE_W-1:0]   acc_eff;
	logic [PHASE_W-1:0]   step_eff;
	logic [SINE_ADDR_BITS-1:0] saddr;
	logic [QB:0]          xm;
	logic                 acc_we;
	logic [VW-1:0]        acc_wa;
	logic [PHASE_W-1:0]   acc_wd;
	logic [SMP_W-1:0]     smp_mag;
	logic [SMP_W-1:0]     smp_val;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && !vld_s1 && !vld_s2;
	assign in_acc   = in_valid && in_ready;
	assign rd_en    = (state_q == ST_TICK) && adv;

	assign sr_clamp = (sr_q < SR_MIN) ? SR_MIN : ((sr_q > SR_MAX) ? SR_MAX : sr_q);

	assign div_r   = {rem_q, dvd_q[DVD_W-1]};
	assign div_ge  = div_r >= {1'b0, srl_q};
	assign div_rem = div_ge ? (div_r - {1'b0, srl_q}) : div_r;

	// Control: configuration, voice flags, sequencing of note loads and ticks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sr_q       <= SR_RESET;
			act_q      <= '0;
			acc_vld_q  <= '0;
			step_vld_q <= '0;
			v_q        <= '0;
			cnt_q      <= '0;
		end else begin
			if (cfg_we)
				sr_q <= cfg_wdata;
			if (acc_we)
				acc_vld_q[acc_wa] <= 1'b1;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (action) begin
							v_q     <= '0;
							state_q <= ST_TICK;
						end else if (int'(voice_index) < VOICES) begin
							act_q[VW'(voice_index)] <= voice_active;
							if (voice_active && velocity != 7'd0)
								state_q <= ST_NOTE;
						end
					end
				end
				ST_NOTE: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(DIV_STEPS - 1))
						state_q <= ST_WR;
				end
				ST_WR: begin
					step_vld_q[nv_q] <= 1'b1;
					state_q          <= ST_IDLE;
				end
				ST_TICK: begin
					if (adv) begin
						v_q <= v_q + 1'b1;
						if (v_q == VW'(VOICES - 1))
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Step divider: ((freq << 12) + sr/2) / sr, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (in_acc) begin
			nv_q   <= VW'(voice_index);
			note_q <= note_number;
			srl_q  <= sr_clamp;
		end
		if (state_q == ST_NOTE) begin
			dvd_q <= DVD_W'({NOTE_TBL[note_q], FRAC_SH'(0)}) + DVD_W'(srl_q >> 1);
			rem_q <= '0;
			quo_q <= '0;
		end else if (state_q == ST_DIV) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= div_rem[SR_W-1:0];
			quo_q <= {quo_q[PHASE_W-2:0], div_ge};
		end
	end

	assign acc_we = (state_q == ST_WR) || (adv && vld_s1 && act_s1);
	assign acc_wa = (state_q == ST_WR) ? nv_q : voice_s1;
	assign acc_wd = (state_q == ST_WR) ? '0 : (acc_eff + step_eff);

	always_ff @(posedge clk) begin
		if (acc_we)
			acc_mem[acc_wa] <= acc_wd;
		if (rd_en)
			acc_rd <= acc_mem[v_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WR)
			step_mem[nv_q] <= quo_q;
		if (rd_en)
			step_rd <= step_mem[v_q];
	end

	assign acc_eff  = accv_s1 ? acc_rd : '0;
	assign step_eff = stepv_s1 ? step_rd : '0;
	assign saddr    = acc_eff[PHASE_W-1 -: SINE_ADDR_BITS];
	assign xm       = saddr[QB] ? ((QB+1)'(QN) - {1'b0, saddr[QB-1:0]})
	                            : {1'b0, saddr[QB-1:0]};

	assign smp_mag = {1'b0, mag_s2};
	assign smp_val = !act_s2 ? '0 : (neg_s2 ? (~smp_mag + 1'b1) : smp_mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= rd_en;
			vld_s2      <= vld_s1;
			out_valid_q <= vld_s2;
		end
	end

	// Tick pipeline: memory read, table read, output register
	always_ff @(posedge clk) begin
		if (adv) begin
			voice_s1    <= v_q;
			last_s1     <= (v_q == VW'(VOICES - 1));
			act_s1      <= act_q[v_q];
			accv_s1     <= acc_vld_q[v_q];
			stepv_s1    <= step_vld_q[v_q];
			voice_s2    <= voice_s1;
			last_s2     <= last_s1;
			act_s2      <= act_s1;
			neg_s2      <= saddr[QB+1];
			mag_s2      <= SINE_TBL[xm];
			out_voice_q <= 3'(voice_s2);
			sample_q    <= smp_val;
			last_q      <= last_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_voice = out_voice_q;
	assign sample    = sample_q;
	assign last      = last_q;

endmodule

@@ dv/tb_top.sv @@
// Testbench for multi_voice_sine_oscillator_core: directed table then random note/tick traffic.
// Predicts per-voice phase, step and sine samples; checks every output transfer in order.
// Depends on mvso_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_top;

	import mvso_pkg::*;

	localparam int NV        = VOICES_DEF;
	localparam int SINE_BITS = SINE_ADDR_BITS_DEF;
	localparam int PHASES    = 6;
	localparam int PER_PHASE = 70;
	localparam int SETTLE    = 80;

	localparam bit ACT_NOTE = 1'b0;
	localparam bit ACT_TICK = 1'b1;

	localparam logic [17:0] RATE_LO = 18'd8000;
	localparam logic [17:0] RATE_HI = 18'd192000;

	localparam longint K1  = 64'sd1686629713;
	localparam longint K3  = -64'sd693598668;
	localparam longint K5  = 64'sd85569306;
	localparam longint K7  = -64'sd5026995;
	localparam longint K9  = 64'sd172272;
	localparam longint ONE = 64'sd1073741824;

	typedef struct packed {
		bit       action;
		bit [2:0] voice;
		bit [6:0] note;
		bit [6:0] vel;
		bit       act;
		bit       zero_tick;
	} stim_t;

	typedef struct packed {
		logic [2:0]              voice;
		logic signed [SMP_W-1:0] smp;
		logic                    lst;
	} voice_out_t;

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    cfg_we       = 1'b0;
	logic [SR_W-1:0]         cfg_wdata    = '0;
	logic                    in_valid     = 1'b0;
	logic                    in_ready;
	logic                    action       = 1'b0;
	logic [2:0]              voice_index  = '0;
	logic [6:0]              note_number  = '0;
	logic [6:0]              velocity     = '0;
	logic                    voice_active = 1'b0;
	logic                    out_valid;
	logic                    out_ready    = 1'b0;
	logic [2:0]              out_voice;
	logic signed [SMP_W-1:0] sample;
	logic                    last;

	logic [31:0] osc_phase [NV];
	logic [31:0] osc_step [NV];
	bit          osc_on [NV];
	logic [17:0] osc_rate;

	voice_out_t  due_samples [$];
	int unsigned mismatch_count = 0;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;

	localparam int DIR_ROWS = 24;
	stim_t note_tick_tbl [DIR_ROWS] = '{
		'{ACT_TICK, 3'd0, 7'd0,   7'd0,   1'b0, 1'b1},
		'{ACT_NOTE, 3'd0, 7'd60,  7'd0,   1'b1, 1'b0},
		'{ACT_TICK, 3'd0, 7'd0,   7'd0,   1'b0, 1'b1},
		'{ACT_NOTE, 3'd1, 7'd0,   7'd127, 1'b1, 1'b0},
		'{ACT_NOTE, 3'd7, 7'd127, 7'd1,   1'b1, 1'b0},
		'{ACT_TICK, 3'd7, 7'd127, 7'd127, 1'b1, 1'b1},
		'{ACT_TICK, 3'd0, 7'd0,   7'd0,   1'b0, 1'b0},
		'{ACT_TICK, 3'd0, 7'd0,   7'd0,   1'b0, 1'b0},
		'{ACT_NOTE, 3'd1, 7'd69,  7'd100, 1'b0, 1'b0},
		'{ACT_TICK, 3'd0, 7'd0,   7'd0,   1'b0, 1'b0},
		'{ACT_NOTE, 3'd1, 7'd12,  7'd0,   1'b1, 1'b0},
		'{ACT_TICK, 3'd0, 7'd0,   7'd0,   1'b0, 1'b0},
		'{ACT_NOTE, 3'd2, 7'd21,  7'd64,  1'b1, 1'b0},
		'{ACT_NOTE, 3'd3, 7'd42,  7'd85,  1'b1, 1'b0},
		'{ACT_NOTE, 3'd4, 7'd84,  7'd42,  1'b1, 1'b0},
		'{ACT_NOTE, 3'd5, 7'd105, 7'd21,  1'b1, 1'b0},
		'{ACT_NOTE, 3'd6, 7'd127, 7'd127, 1'b1, 1'b0},
		'{ACT_TICK, 3'd0, 7'd0,   7'd0,   1'b0, 1'b0},
		'{ACT_TICK, 3'd5, 7'd85,  7'd42,  1'b0, 1'b0},
		'{ACT_TICK, 3'd2, 7'd42,  7'd85,  1'b1, 1'b0},
		'{ACT_NOTE, 3'd7, 7'd0,   7'd127, 1'b0, 1'b0},
		'{ACT_NOTE, 3'd0, 7'd127, 7'd127, 1'b1, 1'b0},
		'{ACT_TICK, 3'd0, 7'd0,   7'd0,   1'b0, 1'b0},
		'{ACT_TICK, 3'd0, 7'd0,   7'd0,   1'b0, 1'b0}
	};

	multi_voice_sine_oscillator_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.voice_index  (voice_index),
		.note_number  (note_number),
		.velocity     (velocity),
		.voice_active (voice_active),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_voice    (out_voice),
		.sample       (sample),
		.last         (last)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] pitch_step(logic [6:0] note, logic [17:0] rate);
		logic [63:0] f;
		logic [63:0] r;
		f = 64'd8572947;
		for (int i = 0; i < note; i++)
			f = (f * 64'd1137589835 + (64'd1 << 29)) >> 30;
		r = 64'(rate);
		if (r < 64'(RATE_LO))
			r = 64'(RATE_LO);
		if (r > 64'(RATE_HI))
			r = 64'(RATE_HI);
		return 32'(((f << 12) + r / 2) / r);
	endfunction

	function automatic logic signed [SMP_W-1:0] sine_of(logic [31:0] ph);
		logic [SINE_BITS-1:0] addr;
		logic [1:0]           quad;
		logic [SINE_BITS-2:0] x;
		longint               t;
		longint               u;
		longint               p;
		longint               s;
		addr = ph[31 -: SINE_BITS];
		quad = addr[SINE_BITS-1 -: 2];
		x    = {1'b0, addr[SINE_BITS-3:0]};
		if (quad[0])
			x = (SINE_BITS-1)'((1 << (SINE_BITS - 2)) - int'(x));
		t = longint'(x) << (30 - (SINE_BITS - 2));
		u = (t * t) / ONE;
		p = K9;
		p = K7 + (p * u) / ONE;
		p = K5 + (p * u) / ONE;
		p = K3 + (p * u) / ONE;
		p = K1 + (p * u) / ONE;
		s = (p * t) / ONE;
		if (s < 0)
			s = 0;
		s = (s + 64'sd16384) / 64'sd32768;
		if (s > 64'sd32767)
			s = 64'sd32767;
		return quad[1] ? -SMP_W'(s) : SMP_W'(s);
	endfunction

	task automatic predict_item(input stim_t s);
		voice_out_t r;
		if (s.action == ACT_NOTE) begin
			if (int'(s.voice) < NV) begin
				osc_on[s.voice] = s.act;
				if (s.act && s.vel != 0) begin
					osc_step[s.voice]  = pitch_step(s.note, osc_rate);
					osc_phase[s.voice] = '0;
				end
			end
		end else begin
			for (int v = 0; v < NV; v++) begin
				r.voice = 3'(v);
				r.smp   = '0;
				r.lst   = (v == NV - 1);
				if (osc_on[v]) begin
					r.smp        = sine_of(osc_phase[v]);
					osc_phase[v] = osc_phase[v] + osc_step[v];
				end
				if (s.zero_tick)
					r.smp = '0;
				due_samples.push_back(r);
			end
		end
	endtask

	task automatic send_item(input stim_t s);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		action       <= s.action;
		voice_index  <= s.voice;
		note_number  <= s.note;
		velocity     <= s.vel;
		voice_active <= s.act;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_item(s);
	endtask

	function automatic stim_t random_item();
		stim_t s;
		s.action    = ($urandom_range(99) < 35) ? ACT_NOTE : ACT_TICK;
		s.voice     = 3'($urandom_range(NV - 1));
		s.note      = 7'($urandom_range(127));
		s.vel       = ($urandom_range(99) < 15) ? 7'd0 : 7'($urandom_range(127, 1));
		s.act       = ($urandom_range(99) < 75);
		s.zero_tick = 1'b0;
		return s;
	endfunction

	// drain, let any pitch load finish, then write the rate
	task automatic set_rate(input logic [17:0] rate);
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= rate;
		@(posedge clk);
		cfg_we   <= 1'b0;
		osc_rate  = rate;
	endtask

	task automatic note_mismatch(input string what, input voice_out_t exp_r, input voice_out_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s: expected voice %0d sample %0d last %0b, got voice %0d sample %0d last %0b",
				$realtime, what, exp_r.voice, exp_r.smp, exp_r.lst, got.voice, got.smp, got.lst);
	endtask

	always @(posedge clk) begin
		voice_out_t got;
		voice_out_t exp_r;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{out_voice, sample, last};
				if (due_samples.size() == 0) begin
					note_mismatch("unexpected transfer", '0, got);
				end else begin
					exp_r = due_samples.pop_front();
					if (got.voice !== exp_r.voice || got.smp !== exp_r.smp || got.lst !== exp_r.lst)
						note_mismatch("sample mismatch", exp_r, got);
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		logic [17:0] rates [PHASES];
		for (int v = 0; v < NV; v++) begin
			osc_phase[v] = '0;
			osc_step[v]  = '0;
			osc_on[v]    = 1'b0;
		end
		osc_rate = SR_RESET;
		rates    = '{SR_RESET, RATE_LO, RATE_HI, 18'd0, 18'h3FFFF,
			18'($urandom_range(262143, 1))};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++)
			send_item(note_tick_tbl[i]);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph != 0)
				set_rate(rates[ph]);
			case (ph % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 61;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 61;
				end
				default: begin
					send_idle_pct  = 10;
					recv_stall_pct = 10;
				end
			endcase
			for (int i = 0; i < PER_PHASE; i++)
				send_item(random_item());
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (due_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0 && due_samples.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("Verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
design/mvso_pkg.sv
design/multi_voice_sine_oscillator_core.sv
dv/tb_top.sv
